FILE: hdl/wfhc_pkg.sv
// ----------------------------------------------------------------------------
// wfhc_pkg
// Shared types and constants of the word frequency hash counter.
// ----------------------------------------------------------------------------
`default_nettype none

package wfhc_pkg;

	localparam int unsigned TABLE_SIZE   = 1024;
	localparam int unsigned SLOT_W       = $clog2(TABLE_SIZE);
	localparam int unsigned MAX_WORD_LEN = 16;
	localparam int unsigned POS_W        = $clog2(MAX_WORD_LEN);
	localparam int unsigned LEN_W        = POS_W + 1;
	localparam int unsigned OCC_W        = SLOT_W + 1;
	localparam int unsigned COUNT_W      = 32;
	localparam int unsigned PADDR_W      = 3;

	localparam logic [63:0] FNV_BASIS   = 64'hCBF29CE484222325;
	localparam logic [8:0]  FNV_PRIME_L = 9'h1B3;
	localparam int unsigned FNV_PRIME_S = 40;

	localparam logic [10:0] LOAD_LIMIT_RST = 11'd819;
	localparam logic [4:0]  WORD_LIMIT_RST = 5'd16;

	typedef enum logic [1:0] {
		OP_TEXT  = 2'd0,
		OP_FLUSH = 2'd1,
		OP_READ  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		KIND_NEW     = 3'd0,
		KIND_COUNTED = 3'd1,
		KIND_DROPPED = 3'd2,
		KIND_BYTE    = 3'd3,
		KIND_EMPTY   = 3'd4
	} kind_t;

	typedef enum logic [0:0] {
		REG_LOAD_LIMIT = 1'b0,
		REG_WORD_LIMIT = 1'b1
	} reg_sel_t;

	typedef struct packed {
		logic [LEN_W-1:0]                  len;
		logic [COUNT_W-1:0]                cnt;
		logic [MAX_WORD_LEN-1:0][7:0]      bytes;
	} row_t;

endpackage

`default_nettype wire

FILE: hdl/wfhc_if.sv
// ----------------------------------------------------------------------------
// wfhc_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface wfhc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] operation;
	logic [7:0] text_byte;
	logic [9:0] slot_index;

	modport source (output valid, operation, text_byte, slot_index, input ready);
	modport sink (input valid, operation, text_byte, slot_index, output ready);
endinterface

interface wfhc_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [9:0]  slot;
	logic [31:0] count;
	logic [7:0]  word_byte;
	logic        last;
	logic        over_limit;

	modport source (output valid, kind, slot, count, word_byte, last, over_limit,
		input ready);
	modport sink (input valid, kind, slot, count, word_byte, last, over_limit,
		output ready);
endinterface

`default_nettype wire

FILE: hdl/wfhc_fnv.sv
// ----------------------------------------------------------------------------
// wfhc_fnv
// One FNV-1a step: xor a byte in, multiply by the 64-bit prime.
// ----------------------------------------------------------------------------
`default_nettype none

module wfhc_fnv (
	input  wire logic [63:0] hash,
	input  wire logic [7:0]  data,
	output logic [63:0]      hash_next
);

	logic [63:0] mixed;
	logic [72:0] low_prod;

	always_comb begin
		mixed     = hash ^ {56'd0, data};
		low_prod  = mixed * {64'd0, wfhc_pkg::FNV_PRIME_L};
		hash_next = (mixed << wfhc_pkg::FNV_PRIME_S) + low_prod[63:0];
	end

endmodule

`default_nettype wire

FILE: hdl/word_frequency_hash_counter_top.sv
// ----------------------------------------------------------------------------
// word_frequency_hash_counter_top
// Splits text into words, hashes them with FNV-1a and counts them in a
// linearly probed table of 1024 slots.
//
//   channel   dir  handshake           payload
//   text_in   in   valid/ready         operation, text_byte, slot_index
//   result    out  valid/ready         kind, slot, count, word_byte, last, over_limit
//   apb       in   psel/penable/pwrite paddr, pwdata, prdata
//
// After reset a clearing pass over all 1024 slots empties the table; no transfer
// is taken meanwhile. Stalls on the result channel hold the sequencer. A text
// byte that ends no word leaves it idle. A word end probes slot by slot, a read
// and a check state per slot (one table read port), then gives one result.
// A slot read passes both states, then one result per stored byte or one if empty.
// ----------------------------------------------------------------------------
`default_nettype none

module word_frequency_hash_counter_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	wfhc_in_if.sink                           text_in,
	wfhc_out_if.source                        result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [wfhc_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int unsigned SW = wfhc_pkg::SLOT_W;
	localparam int unsigned LW = wfhc_pkg::LEN_W;

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_PRD   = 7'b0000100,
		ST_PCHK  = 7'b0001000,
		ST_RRD   = 7'b0010000,
		ST_RCHK  = 7'b0100000,
		ST_EMIT  = 7'b1000000
	} state_t;

	state_t state_q;

	logic [10:0]    load_limit_q;
	logic [4:0]     word_limit_q;
	logic [LW-1:0]  eff_limit;

	logic [wfhc_pkg::MAX_WORD_LEN-1:0][7:0] buf_q;
	logic [LW-1:0]  fill_q;
	logic [LW-1:0]  fill_inc;
	logic [63:0]    hash_q;
	logic [63:0]    hash_next;
	logic [wfhc_pkg::OCC_W-1:0] occ_q;

	logic [SW-1:0]  slot_q;
	logic [SW-1:0]  probe_n_q;
	logic [wfhc_pkg::POS_W-1:0] k_q;

	wfhc_pkg::row_t mem [wfhc_pkg::TABLE_SIZE];
	wfhc_pkg::row_t rd_q;
	wfhc_pkg::row_t wr_row;
	logic           mem_we;

	logic [2:0]     kind_q;
	logic [SW-1:0]  oslot_q;
	logic [31:0]    count_q;
	logic [7:0]     obyte_q;
	logic           last_q;

	logic           is_space;
	logic           word_match;
	logic [31:0]    cnt_inc;
	logic           in_xfer;
	logic           out_xfer;
	logic           cfg_wr;

	wfhc_fnv u_fnv (
		.hash      (hash_q),
		.data      (text_in.text_byte),
		.hash_next (hash_next)
	);

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign prdata  = (paddr[2] == wfhc_pkg::REG_WORD_LIMIT) ? {27'd0, word_limit_q}
		: {21'd0, load_limit_q};

	assign text_in.ready     = (state_q == ST_IDLE);
	assign in_xfer           = text_in.valid && text_in.ready;
	assign result.valid      = (state_q == ST_EMIT);
	assign out_xfer          = result.valid && result.ready;
	assign result.kind       = kind_q;
	assign result.slot       = oslot_q;
	assign result.count      = count_q;
	assign result.word_byte  = obyte_q;
	assign result.last       = last_q;
	assign result.over_limit = ({1'b0, occ_q} > {1'b0, load_limit_q});

	always_comb begin
		if (word_limit_q == 5'd0) begin
			eff_limit = LW'(1);
		end else if (word_limit_q > 5'(wfhc_pkg::MAX_WORD_LEN)) begin
			eff_limit = LW'(wfhc_pkg::MAX_WORD_LEN);
		end else begin
			eff_limit = LW'(word_limit_q);
		end
		fill_inc = fill_q + LW'(1);
		is_space = text_in.text_byte inside {8'h20, [8'h09:8'h0D]};
		word_match = (rd_q.len == fill_q);
		for (int i = 0; i < wfhc_pkg::MAX_WORD_LEN; i++) begin
			if ((LW'(i) < fill_q) && (rd_q.bytes[i] != buf_q[i])) begin
				word_match = 1'b0;
			end
		end
		cnt_inc = (rd_q.cnt == 32'hFFFF_FFFF) ? rd_q.cnt : rd_q.cnt + 32'd1;
	end

	always_comb begin
		mem_we = 1'b0;
		wr_row = '{len: '0, cnt: '0, bytes: buf_q};
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == ST_PCHK) begin
			if (rd_q.len == '0) begin
				mem_we = 1'b1;
				wr_row = '{len: fill_q, cnt: 32'd1, bytes: buf_q};
			end else if (word_match) begin
				mem_we = 1'b1;
				wr_row = '{len: rd_q.len, cnt: cnt_inc, bytes: rd_q.bytes};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_q] <= wr_row;
		end
		rd_q <= mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_limit_q <= wfhc_pkg::LOAD_LIMIT_RST;
			word_limit_q <= wfhc_pkg::WORD_LIMIT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == wfhc_pkg::REG_LOAD_LIMIT) begin
				load_limit_q <= pwdata[10:0];
			end else begin
				word_limit_q <= pwdata[4:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && text_in.operation == wfhc_pkg::OP_TEXT && !is_space) begin
			buf_q[fill_q[wfhc_pkg::POS_W-1:0]] <= text_in.text_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			fill_q    <= '0;
			hash_q    <= wfhc_pkg::FNV_BASIS;
			occ_q     <= '0;
			slot_q    <= '0;
			probe_n_q <= '0;
			k_q       <= '0;
			kind_q    <= '0;
			oslot_q   <= '0;
			count_q   <= '0;
			obyte_q   <= '0;
			last_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					slot_q <= slot_q + SW'(1);
					if (slot_q == SW'(wfhc_pkg::TABLE_SIZE - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer) begin
						probe_n_q <= '0;
						case (text_in.operation)
							wfhc_pkg::OP_TEXT: begin
								if (is_space) begin
									if (fill_q != '0) begin
										slot_q  <= hash_q[SW-1:0];
										state_q <= ST_PRD;
									end
								end else begin
									fill_q <= fill_inc;
									hash_q <= hash_next;
									if (fill_inc >= eff_limit) begin
										slot_q  <= hash_next[SW-1:0];
										state_q <= ST_PRD;
									end
								end
							end
							wfhc_pkg::OP_FLUSH: begin
								if (fill_q != '0) begin
									slot_q  <= hash_q[SW-1:0];
									state_q <= ST_PRD;
								end
							end
							wfhc_pkg::OP_READ: begin
								slot_q  <= text_in.slot_index;
								state_q <= ST_RRD;
							end
							default: begin
							end
						endcase
					end
				end
				ST_PRD: begin
					state_q <= ST_PCHK;
				end
				ST_PCHK: begin
					oslot_q <= slot_q;
					obyte_q <= '0;
					last_q  <= 1'b1;
					if (rd_q.len == '0) begin
						kind_q  <= wfhc_pkg::KIND_NEW;
						count_q <= 32'd1;
						occ_q   <= occ_q + wfhc_pkg::OCC_W'(1);
					end else if (word_match) begin
						kind_q  <= wfhc_pkg::KIND_COUNTED;
						count_q <= cnt_inc;
					end else if (probe_n_q == SW'(wfhc_pkg::TABLE_SIZE - 1)) begin
						kind_q  <= wfhc_pkg::KIND_DROPPED;
						count_q <= '0;
						oslot_q <= hash_q[SW-1:0];
					end
					if (rd_q.len == '0 || word_match
							|| probe_n_q == SW'(wfhc_pkg::TABLE_SIZE - 1)) begin
						fill_q  <= '0;
						hash_q  <= wfhc_pkg::FNV_BASIS;
						state_q <= ST_EMIT;
					end else begin
						slot_q    <= slot_q + SW'(1);
						probe_n_q <= probe_n_q + SW'(1);
						state_q   <= ST_PRD;
					end
				end
				ST_RRD: begin
					state_q <= ST_RCHK;
				end
				ST_RCHK: begin
					oslot_q <= slot_q;
					k_q     <= '0;
					state_q <= ST_EMIT;
					if (rd_q.len == '0) begin
						kind_q  <= wfhc_pkg::KIND_EMPTY;
						count_q <= '0;
						obyte_q <= '0;
						last_q  <= 1'b1;
					end else begin
						kind_q  <= wfhc_pkg::KIND_BYTE;
						count_q <= rd_q.cnt;
						obyte_q <= rd_q.bytes[0];
						last_q  <= (rd_q.len == LW'(1));
					end
				end
				ST_EMIT: begin
					if (out_xfer) begin
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + wfhc_pkg::POS_W'(1);
							obyte_q <= rd_q.bytes[k_q + wfhc_pkg::POS_W'(1)];
							last_q  <= ({1'b0, k_q} + LW'(2) == rd_q.len);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !text_in.ready)
		else $error("transfer possible during table clear");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= wfhc_pkg::OCC_W'(wfhc_pkg::TABLE_SIZE))
		else $error("occupied count beyond table size");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> fill_q < LW'(wfhc_pkg::MAX_WORD_LEN))
		else $error("word buffer full while idle");

	a_new_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && kind_q == wfhc_pkg::KIND_NEW |-> count_q == 32'd1 && last_q)
		else $error("new word result with wrong count");

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives text bytes, flushes and slot reads into the word frequency hash
// counter under random idling on both channels, predicts every result from
// its own copy of the hash table and compares each result field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

	localparam logic [1:0] OP_SPARE    = 2'd3;
	localparam int unsigned SETTLE_CYC = 60;
	localparam int unsigned CYCLE_CAP  = 400000;

	typedef struct {
		wfhc_pkg::kind_t kind;
		logic [9:0]  slot;
		logic [31:0] count;
		logic [7:0]  word_byte;
		logic        last;
		logic        over_limit;
	} tally_t;

	class word_tally_board;
		logic [7:0]  keys [wfhc_pkg::TABLE_SIZE][wfhc_pkg::MAX_WORD_LEN];
		int unsigned key_len [wfhc_pkg::TABLE_SIZE];
		logic [31:0] counts [wfhc_pkg::TABLE_SIZE];
		int unsigned occupied;
		logic [7:0]  word [wfhc_pkg::MAX_WORD_LEN];
		int unsigned fill;
		logic [63:0] hash;
		logic [10:0] load_limit;
		logic [4:0]  word_limit;
		tally_t      pending [$];
		int unsigned errors, items, results, new_words, recounts, slot_bytes;

		function new();
			for (int i = 0; i < wfhc_pkg::TABLE_SIZE; i++) key_len[i] = 0;
			occupied = 0; fill = 0; hash = wfhc_pkg::FNV_BASIS;
			load_limit = wfhc_pkg::LOAD_LIMIT_RST; word_limit = wfhc_pkg::WORD_LIMIT_RST;
			errors = 0; items = 0; results = 0;
			new_words = 0; recounts = 0; slot_bytes = 0;
		endfunction

		function void push(wfhc_pkg::kind_t k, int unsigned s, logic [31:0] c,
				logic [7:0] b, logic l);
			tally_t t;
			t.kind = k; t.slot = s[9:0]; t.count = c; t.word_byte = b; t.last = l;
			t.over_limit = (occupied > load_limit);
			pending.push_back(t);
		endfunction

		function void end_word();
			int unsigned home, i;
			bit done, same;
			home = 32'(hash % 64'(wfhc_pkg::TABLE_SIZE));
			i = home;
			done = 0;
			for (int n = 0; n < wfhc_pkg::TABLE_SIZE && !done; n++) begin
				if (key_len[i] == 0) begin
					for (int k = 0; k < fill; k++) keys[i][k] = word[k];
					key_len[i] = fill; counts[i] = 32'd1; occupied++;
					push(wfhc_pkg::KIND_NEW, i, 32'd1, 8'd0, 1'b1);
					done = 1;
				end else if (key_len[i] == fill) begin
					same = 1;
					for (int k = 0; k < fill; k++) if (keys[i][k] != word[k]) same = 0;
					if (same) begin
						if (counts[i] != 32'hFFFF_FFFF) counts[i]++;
						push(wfhc_pkg::KIND_COUNTED, i, counts[i], 8'd0, 1'b1);
						done = 1;
					end
				end
				i = (i + 1) % wfhc_pkg::TABLE_SIZE;
			end
			if (!done) push(wfhc_pkg::KIND_DROPPED, home, 32'd0, 8'd0, 1'b1);
			fill = 0; hash = wfhc_pkg::FNV_BASIS;
		endfunction

		function void note_item(logic [1:0] op, logic [7:0] b, logic [9:0] idx);
			int unsigned lim;
			items++;
			if (op == wfhc_pkg::OP_TEXT) begin
				if (b == 8'h20 || (b >= 8'h09 && b <= 8'h0D)) begin
					if (fill > 0) end_word();
				end else begin
					if (fill < wfhc_pkg::MAX_WORD_LEN) begin
						word[fill] = b; fill++;
					end
					hash = (hash ^ {56'd0, b}) * 64'd1099511628211;
					lim = 32'(word_limit);
					if (lim < 1) lim = 1;
					if (lim > wfhc_pkg::MAX_WORD_LEN) lim = wfhc_pkg::MAX_WORD_LEN;
					if (fill >= lim) end_word();
				end
			end else if (op == wfhc_pkg::OP_FLUSH) begin
				if (fill > 0) end_word();
			end else if (op == wfhc_pkg::OP_READ) begin
				if (key_len[idx] == 0) push(wfhc_pkg::KIND_EMPTY, 32'(idx), 32'd0, 8'd0, 1'b1);
				else for (int k = 0; k < key_len[idx]; k++)
					push(wfhc_pkg::KIND_BYTE, 32'(idx), counts[idx], keys[idx][k],
						k + 1 == key_len[idx]);
			end
		endfunction

		function void check_result(tally_t got);
			tally_t want;
			results++;
			if (pending.size() == 0) begin
				$error("result with nothing pending: kind %0d slot %0d", got.kind, got.slot);
				errors++;
				return;
			end
			want = pending.pop_front();
			case (want.kind)
				wfhc_pkg::KIND_NEW:     new_words++;
				wfhc_pkg::KIND_COUNTED: recounts++;
				wfhc_pkg::KIND_BYTE:    slot_bytes++;
				default: ;
			endcase
			if (got.kind != want.kind) begin
				$error("kind: expected %0d actual %0d", want.kind, got.kind); errors++;
			end
			if (got.slot != want.slot) begin
				$error("slot: expected %0d actual %0d", want.slot, got.slot); errors++;
			end
			if (got.count != want.count) begin
				$error("count: expected %0d actual %0d", want.count, got.count); errors++;
			end
			if (got.word_byte != want.word_byte) begin
				$error("word_byte: expected %0h actual %0h", want.word_byte, got.word_byte);
				errors++;
			end
			if (got.last != want.last) begin
				$error("last: expected %0d actual %0d", want.last, got.last); errors++;
			end
			if (got.over_limit != want.over_limit) begin
				$error("over_limit: expected %0d actual %0d", want.over_limit,
					got.over_limit);
				errors++;
			end
		endfunction

		function int unsigned pick_slot();
			int unsigned s;
			s = $urandom_range(0, wfhc_pkg::TABLE_SIZE - 1);
			for (int n = 0; n < wfhc_pkg::TABLE_SIZE; n++) begin
				if (key_len[(s + n) % wfhc_pkg::TABLE_SIZE] != 0)
					return (s + n) % wfhc_pkg::TABLE_SIZE;
			end
			return s;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [wfhc_pkg::PADDR_W-1:0] paddr;
	logic [31:0] pwdata, prdata;
	logic        pready;
	int unsigned send_gap_max, take_gap_max;
	int unsigned cycles;
	bit          held_once;

	wfhc_in_if  text_in_ch ();
	wfhc_out_if result_ch ();

	word_tally_board board = new();

	word_frequency_hash_counter_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.text_in (text_in_ch.sink),
		.result  (result_ch.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic write_reg(wfhc_pkg::reg_sel_t sel, logic [31:0] val);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {sel, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (sel == wfhc_pkg::REG_LOAD_LIMIT) board.load_limit = val[10:0];
		else board.word_limit = val[4:0];
	endtask

	task automatic settle();
		while (board.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic send(logic [1:0] op, logic [7:0] b, logic [9:0] idx);
		int unsigned gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			text_in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_in_ch.valid <= 1'b1;
		text_in_ch.operation <= op;
		text_in_ch.text_byte <= b;
		text_in_ch.slot_index <= idx;
		do @(posedge clk); while (!text_in_ch.ready);
		board.note_item(op, b, idx);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send(wfhc_pkg::OP_TEXT, s[i], 10'($urandom));
	endtask

	task automatic send_random(int unsigned n);
		int unsigned r;
		logic [7:0] b;
		byte        alpha [6] = '{"a", "b", "c", "d", "e", " "};
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				r = $urandom_range(0, 99);
				if (r < 72) b = alpha[$urandom_range(0, 5)];
				else if (r < 88) b = ($urandom_range(0, 1)) ? 8'h20 : 8'($urandom_range(9, 13));
				else b = 8'($urandom);
				send(wfhc_pkg::OP_TEXT, b, 10'($urandom));
			end else if (r < 87) send(wfhc_pkg::OP_FLUSH, 8'($urandom), 10'($urandom));
			else if (r < 94) send(wfhc_pkg::OP_READ, 8'($urandom), 10'(board.pick_slot()));
			else if (r < 97) send(wfhc_pkg::OP_READ, 8'($urandom), 10'($urandom));
			else send(OP_SPARE, 8'($urandom), 10'($urandom));
		end
		text_in_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		tally_t got;
		int unsigned gap;
		result_ch.ready <= 1'b0;
		held_once = 0;
		@(posedge arst_n);
		forever begin
			if (!held_once && board.results == 40) begin
				held_once = 1;
				result_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			gap = $urandom_range(0, take_gap_max);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			got.kind = wfhc_pkg::kind_t'(result_ch.kind);
			got.slot = result_ch.slot;
			got.count = result_ch.count;
			got.word_byte = result_ch.word_byte;
			got.last = result_ch.last;
			got.over_limit = result_ch.over_limit;
			board.check_result(got);
		end
	end

	initial begin
		int unsigned cat_slot;
		arst_n <= 1'b0;
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		paddr <= '0; pwdata <= '0;
		text_in_ch.valid <= 1'b0;
		text_in_ch.operation <= wfhc_pkg::OP_TEXT;
		text_in_ch.text_byte <= 8'h00;
		text_in_ch.slot_index <= '0;
		send_gap_max = 4; take_gap_max = 4;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("cat cat\t");
		send(wfhc_pkg::OP_FLUSH, 8'h00, 10'd0);
		send(wfhc_pkg::OP_TEXT, 8'h20, 10'd0);
		send(wfhc_pkg::OP_TEXT, 8'h00, 10'd0);
		send(wfhc_pkg::OP_TEXT, 8'hFF, 10'd0);
		send(wfhc_pkg::OP_TEXT, 8'h08, 10'd0);
		send(wfhc_pkg::OP_TEXT, 8'h0E, 10'd0);
		send(wfhc_pkg::OP_TEXT, 8'h0D, 10'd0);
		send_text("dog");
		send(wfhc_pkg::OP_FLUSH, 8'h00, 10'd0);
		cat_slot = board.pick_slot();
		send(wfhc_pkg::OP_READ, 8'h00, 10'(cat_slot));
		send(wfhc_pkg::OP_READ, 8'h00, 10'h3FF);
		send(OP_SPARE, 8'hFF, 10'h3FF);
		send_text("abcdefghijklmnopq\n\v\f");
		text_in_ch.valid <= 1'b0;
		@(posedge clk);
		settle();

		write_reg(wfhc_pkg::REG_LOAD_LIMIT, 32'd0);
		write_reg(wfhc_pkg::REG_WORD_LIMIT, 32'd0);
		send_gap_max = 0; take_gap_max = 0;
		send_random(50);
		settle();

		write_reg(wfhc_pkg::REG_LOAD_LIMIT, 32'd1024);
		write_reg(wfhc_pkg::REG_WORD_LIMIT, 32'd31);
		send_gap_max = 4; take_gap_max = 4;
		send_random(60);
		settle();

		write_reg(wfhc_pkg::REG_LOAD_LIMIT, 32'd4);
		write_reg(wfhc_pkg::REG_WORD_LIMIT, 32'd1);
		send_random(30);
		settle();

		write_reg(wfhc_pkg::REG_LOAD_LIMIT, 32'($urandom_range(5, 30)));
		write_reg(wfhc_pkg::REG_WORD_LIMIT, 32'($urandom_range(2, 16)));
		send_random(50);
		settle();

		$display("Ran %0d input transfers giving %0d results: %0d new words, %0d recounts,",
			board.items, board.results, board.new_words, board.recounts);
		$display("%0d slot bytes, over four register settings and one long result stall.",
			board.slot_bytes);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

`default_nettype wire
